@@ src/opf_pkg.sv @@
// Package for the odometry pose fusion block: fixed-point constants and the
// CORDIC arctangent table. No dependencies.
package opf_pkg;

    localparam logic signed [63:0] Q28_PI      = 64'sd843314857;
    localparam logic signed [63:0] Q28_TWO_PI  = 64'sd1686629713;
    localparam logic signed [63:0] Q28_HALF_PI = 64'sd421657428;
    localparam logic signed [31:0] CAM_LIMIT   = 32'sd327680000;
    localparam logic signed [63:0] CORDIC_GAIN = 64'sd652032874;
    localparam int unsigned CORDIC_STEPS       = 28;

    localparam logic [15:0] RADIUS_RESET = 16'd4719;
    localparam logic [23:0] INV_TRACK_RESET = 24'd262144;

    localparam logic signed [31:0] FUSED_X_RESET = 32'sd78643;
    localparam logic signed [31:0] FUSED_Y_RESET = 32'sd116654;
    localparam logic signed [31:0] FUSED_H_RESET = -32'sd421657428;

    // Opcodes of an input word.
    localparam logic [1:0] OP_ENCODER = 2'd0;
    localparam logic [1:0] OP_CAMERA  = 2'd1;
    localparam logic [1:0] OP_TOGGLE  = 2'd2;
    localparam logic [1:0] OP_TICK    = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_RADIUS_LEFT  = 2'd0;
    localparam logic [1:0] CFG_RADIUS_RIGHT = 2'd1;
    localparam logic [1:0] CFG_INV_TRACK    = 2'd2;

    // Arctangent of 2^-i in Q2.30.
    function automatic logic signed [63:0] atan_entry(input logic [4:0] i);
        logic signed [63:0] r;
        case (i)
            5'd0: r = 64'sd843314857;
            5'd1: r = 64'sd497837829;
            5'd2: r = 64'sd263043837;
            5'd3: r = 64'sd133525159;
            5'd4: r = 64'sd67021687;
            5'd5: r = 64'sd33543516;
            5'd6: r = 64'sd16775851;
            5'd7: r = 64'sd8388437;
            5'd8: r = 64'sd4194283;
            5'd9: r = 64'sd2097149;
            default: r = 64'sd1 <<< (6'd30 - {1'b0, i});
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

@@ src/odometry_pose_fusion.sv @@
// Odometry pose fusion: an encoder word stalls the input through the products,
// the CORDIC (angle reduction by at most two turns, one fold, then 28 rotations)
// and a two-pass pose update. Camera, toggle and non-publishing tick words are
// taken without stalling the input; a publishing tick loads its pose into the
// output register and holds the input until that pose is taken. Reset restores
// radii and start pose.
module odometry_pose_fusion
    import opf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         opcode,
    input  logic signed [31:0] wheel_delta_left,
    input  logic signed [31:0] wheel_delta_right,
    input  logic signed [31:0] cam_x,
    input  logic signed [31:0] cam_y,
    input  logic signed [31:0] cam_heading,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] pose_x,
    output logic signed [31:0] pose_y,
    output logic signed [31:0] pose_heading,
    output logic               pose_source
);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_DPHI, S_TRIG, S_WAIT, S_MULX, S_POSE, S_OUT
    } state_t;

    state_t             state_reg;
    logic [15:0]        rl_reg, rr_reg;
    logic [23:0]        it_reg;
    logic signed [31:0] fx_reg, fy_reg, fh_reg;
    logic signed [31:0] ox_reg, oy_reg, oh_reg;
    logic signed [31:0] cx_reg, cy_reg, ch_reg;
    logic               cfresh_reg, ofresh_reg, cmode_reg;
    logic signed [31:0] dl_reg, dr_reg;
    logic signed [63:0] pl_reg, pr_reg, dphi_reg;
    logic signed [31:0] ds_reg, c_reg, s_reg;
    logic signed [63:0] px_reg, py_reg;
    logic signed [33:0] diff_reg;
    logic               pose_pass_reg;

    logic               cor_start, cor_done;
    logic signed [63:0] cor_angle, cor_cos, cor_sin;
    logic signed [63:0] h_sum;

    assign in_stall  = (state_reg != S_IDLE);
    assign cor_start = (state_reg == S_TRIG);
    assign cor_angle = 64'(fh_reg) + (dphi_reg >>> 1);
    assign h_sum     = 64'(fh_reg) + dphi_reg;

    opf_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cor_start),
        .angle   (cor_angle),
        .done    (cor_done),
        .cos_out (cor_cos),
        .sin_out (cor_sin)
    );

    // Sequencer, pose state and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rl_reg        <= RADIUS_RESET;
            rr_reg        <= RADIUS_RESET;
            it_reg        <= INV_TRACK_RESET;
            fx_reg        <= FUSED_X_RESET;
            fy_reg        <= FUSED_Y_RESET;
            fh_reg        <= FUSED_H_RESET;
            ox_reg        <= '0;
            oy_reg        <= '0;
            oh_reg        <= '0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            ch_reg        <= '0;
            cfresh_reg    <= 1'b0;
            ofresh_reg    <= 1'b0;
            cmode_reg     <= 1'b0;
            out_valid     <= 1'b0;
            pose_pass_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_RADIUS_LEFT:  rl_reg <= cfg_data[15:0];
                    CFG_RADIUS_RIGHT: rr_reg <= cfg_data[15:0];
                    CFG_INV_TRACK:    it_reg <= cfg_data;
                    default: ;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        case (opcode)
                            OP_ENCODER:
                            begin
                                dl_reg    <= wheel_delta_left;
                                dr_reg    <= wheel_delta_right;
                                state_reg <= S_MUL;
                            end
                            OP_CAMERA:
                            begin
                                cx_reg     <= cam_x;
                                cy_reg     <= cam_y;
                                ch_reg     <= cam_heading;
                                cfresh_reg <= (cam_x < CAM_LIMIT);
                            end
                            OP_TOGGLE:
                            begin
                                cmode_reg <= !cmode_reg;
                            end
                            OP_TICK:
                            begin
                                if (cmode_reg && cfresh_reg)
                                begin
                                    fx_reg      <= cx_reg;
                                    fy_reg      <= cy_reg;
                                    fh_reg      <= ch_reg;
                                    pose_x      <= cx_reg;
                                    pose_y      <= cy_reg;
                                    pose_heading <= ch_reg;
                                    pose_source <= 1'b0;
                                    cfresh_reg  <= 1'b0;
                                    ofresh_reg  <= 1'b0;
                                    out_valid   <= 1'b1;
                                    state_reg   <= S_OUT;
                                end
                                else if (ofresh_reg)
                                begin
                                    fx_reg      <= ox_reg;
                                    fy_reg      <= oy_reg;
                                    fh_reg      <= oh_reg;
                                    pose_x      <= ox_reg;
                                    pose_y      <= oy_reg;
                                    pose_heading <= oh_reg;
                                    pose_source <= 1'b1;
                                    cfresh_reg  <= 1'b0;
                                    ofresh_reg  <= 1'b0;
                                    out_valid   <= 1'b1;
                                    state_reg   <= S_OUT;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_MUL:
                begin
                    pl_reg    <= $signed({1'b0, rl_reg}) * dl_reg;
                    pr_reg    <= $signed({1'b0, rr_reg}) * dr_reg;
                    state_reg <= S_DPHI;
                end
                S_DPHI:
                begin
                    ds_reg    <= sat32((pl_reg + pr_reg) >>> 17);
                    diff_reg  <= 34'((pr_reg - pl_reg) >>> 16);
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    // Heading change: scaled wheel difference times inverse track.
                    dphi_reg  <= 64'(sat32((diff_reg * $signed({1'b0, it_reg})) >>> 4));
                    state_reg <= S_TRIG;
                end
                S_TRIG:
                begin
                    state_reg <= S_MULX;
                end
                S_MULX:
                begin
                    if (cor_done)
                    begin
                        c_reg     <= cor_cos[31:0];
                        s_reg     <= cor_sin[31:0];
                        state_reg <= S_POSE;
                    end
                end
                S_POSE:
                begin
                    // Two passes: first the products, then the sums.
                    if (!pose_pass_reg)
                    begin
                        px_reg        <= ds_reg * c_reg;
                        py_reg        <= ds_reg * s_reg;
                        pose_pass_reg <= 1'b1;
                    end
                    else
                    begin
                        ox_reg <= sat32(64'(fx_reg) + (px_reg >>> 30));
                        oy_reg <= sat32(64'(fy_reg) + (py_reg >>> 30));
                        if (h_sum > Q28_PI)
                            oh_reg <= sat32(h_sum - Q28_TWO_PI);
                        else if (h_sum <= -Q28_PI)
                            oh_reg <= sat32(h_sum + Q28_TWO_PI);
                        else
                            oh_reg <= sat32(h_sum);
                        ofresh_reg    <= 1'b1;
                        pose_pass_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        out_valid <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ src/opf_cordic.sv @@
// Iterative CORDIC unit: one rotation a cycle, giving cos and sin in Q2.30.
// Depends on opf_pkg.
module opf_cordic
    import opf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [63:0]  angle,
    output logic                done,
    output logic signed [63:0]  cos_out,
    output logic signed [63:0]  sin_out
);

    typedef enum logic [1:0] {S_IDLE, S_REDUCE, S_ROTATE, S_DONE} cstate_t;

    cstate_t            state_reg;
    logic signed [63:0] x_reg, y_reg, z_reg, a_reg;
    logic [4:0]         step_reg;
    logic [5:0]         guard_reg;
    logic               neg_reg;

    logic signed [63:0] ys, xs, zs_at;
    assign ys    = y_reg >>> step_reg;
    assign xs    = x_reg >>> step_reg;
    assign zs_at = atan_entry(step_reg);

    // Output negation for angles folded from the far half-plane.
    assign done    = (state_reg == S_DONE);
    assign cos_out = neg_reg ? -x_reg : x_reg;
    assign sin_out = neg_reg ? -y_reg : y_reg;

    // Sequencer: reduce the angle one turn a cycle, fold, then rotate.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            guard_reg <= '0;
            neg_reg   <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        a_reg     <= angle;
                        guard_reg <= '0;
                        state_reg <= S_REDUCE;
                    end
                end
                S_REDUCE:
                begin
                    if (a_reg > Q28_PI && guard_reg < 6'd16)
                    begin
                        a_reg     <= a_reg - Q28_TWO_PI;
                        guard_reg <= guard_reg + 6'd1;
                    end
                    else if (a_reg <= -Q28_PI && guard_reg < 6'd32)
                    begin
                        a_reg     <= a_reg + Q28_TWO_PI;
                        guard_reg <= guard_reg + 6'd1;
                    end
                    else
                    begin
                        if (a_reg > Q28_HALF_PI)
                        begin
                            z_reg   <= (a_reg - Q28_PI) <<< 2;
                            neg_reg <= 1'b1;
                        end
                        else if (a_reg < -Q28_HALF_PI)
                        begin
                            z_reg   <= (a_reg + Q28_PI) <<< 2;
                            neg_reg <= 1'b1;
                        end
                        else
                        begin
                            z_reg   <= a_reg <<< 2;
                            neg_reg <= 1'b0;
                        end
                        x_reg     <= CORDIC_GAIN;
                        y_reg     <= '0;
                        step_reg  <= '0;
                        state_reg <= S_ROTATE;
                    end
                end
                S_ROTATE:
                begin
                    if (z_reg >= 0)
                    begin
                        x_reg <= x_reg - ys;
                        y_reg <= y_reg + xs;
                        z_reg <= z_reg - zs_at;
                    end
                    else
                    begin
                        x_reg <= x_reg + ys;
                        y_reg <= y_reg - xs;
                        z_reg <= z_reg + zs_at;
                    end
                    if (step_reg == 5'(CORDIC_STEPS - 1))
                        state_reg <= S_DONE;
                    step_reg <= step_reg + 5'd1;
                end
                S_DONE:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ sim/opf_checker.sv @@
// Checker for the odometry pose fusion block: watches the configuration port and both
// word channels, predicts every published pose and compares it field by field.
// Depends on opf_pkg for opcodes, register indexes and fixed-point constants.
`timescale 1ns / 100ps

module opf_checker
    import opf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [1:0]         opcode,
    input  logic signed [31:0] wheel_delta_left,
    input  logic signed [31:0] wheel_delta_right,
    input  logic signed [31:0] cam_x,
    input  logic signed [31:0] cam_y,
    input  logic signed [31:0] cam_heading,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [31:0] pose_x,
    input  logic signed [31:0] pose_y,
    input  logic signed [31:0] pose_heading,
    input  logic               pose_source,
    output int                 errors,
    output int                 pending,
    output int                 poses_checked,
    output int                 words_taken
);

    localparam logic SRC_CAMERA   = 1'b0;
    localparam logic SRC_ODOMETRY = 1'b1;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] heading;
        logic               source;
    } pose_t;

    // Mirror of the tracker state.
    longint rad_l, rad_r, inv_track;
    longint fused[3], odom[3], camera[3];
    logic   camera_fresh, odom_fresh, camera_mode;
    pose_t  expected_poses[$];

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint arctan_step(input int i);
        longint tbl[10];
        tbl = '{843314857, 497837829, 263043837, 133525159, 67021687,
                33543516, 16775851, 8388437, 4194283, 2097149};
        if (i < 10)
            return tbl[i];
        return longint'(1) <<< (30 - i);
    endfunction

    // CORDIC rotation: angle Q4.28 in, cosine and sine Q2.30 out.
    task automatic rotate(input longint a, output longint c, output longint s);
        int     guard;
        logic   flip;
        longint cx, cy, z, t;
        guard = 0;
        flip  = 1'b0;
        cx    = CORDIC_GAIN;
        cy    = 0;
        while (a > Q28_PI && guard < 16)
        begin
            a -= Q28_TWO_PI;
            guard++;
        end
        while (a <= -Q28_PI && guard < 32)
        begin
            a += Q28_TWO_PI;
            guard++;
        end
        if (a > Q28_HALF_PI)
        begin
            a -= Q28_PI;
            flip = 1'b1;
        end
        else if (a < -Q28_HALF_PI)
        begin
            a += Q28_PI;
            flip = 1'b1;
        end
        z = a * 4;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            if (z >= 0)
            begin
                t  = cx - (cy >>> i);
                cy = cy + (cx >>> i);
                cx = t;
                z -= arctan_step(i);
            end
            else
            begin
                t  = cx + (cy >>> i);
                cy = cy - (cx >>> i);
                cx = t;
                z += arctan_step(i);
            end
        end
        c = flip ? -cx : cx;
        s = flip ? -cy : cy;
    endtask

    // Dead-reckoning step from the last published pose.
    task automatic advance_odometry(input longint dl, input longint dr);
        longint ds, dphi, c, s, h;
        ds   = clamp32((rad_l * dl + rad_r * dr) >>> 17);
        dphi = clamp32((((rad_r * dr - rad_l * dl) >>> 16) * inv_track) >>> 4);
        rotate(fused[2] + (dphi >>> 1), c, s);
        odom[0] = clamp32(fused[0] + ((ds * c) >>> 30));
        odom[1] = clamp32(fused[1] + ((ds * s) >>> 30));
        h = fused[2] + dphi;
        if (h > Q28_PI)
            h -= Q28_TWO_PI;
        else if (h <= -Q28_PI)
            h += Q28_TWO_PI;
        odom[2] = clamp32(h);
    endtask

    task automatic publish_tick();
        pose_t p;
        if (camera_mode && camera_fresh)
        begin
            fused    = camera;
            p.source = SRC_CAMERA;
        end
        else if (odom_fresh)
        begin
            fused    = odom;
            p.source = SRC_ODOMETRY;
        end
        else
            return;
        camera_fresh = 1'b0;
        odom_fresh   = 1'b0;
        p.x       = fused[0][31:0];
        p.y       = fused[1][31:0];
        p.heading = fused[2][31:0];
        expected_poses.push_back(p);
    endtask

    // Prediction on accepted words, comparison on accepted results.
    always @(posedge clk or negedge rst_n)
    begin
        pose_t e;
        if (!rst_n)
        begin
            rad_l        = longint'(RADIUS_RESET);
            rad_r        = longint'(RADIUS_RESET);
            inv_track    = longint'(INV_TRACK_RESET);
            fused        = '{FUSED_X_RESET, FUSED_Y_RESET, FUSED_H_RESET};
            odom         = '{0, 0, 0};
            camera       = '{0, 0, 0};
            camera_fresh = 1'b0;
            odom_fresh   = 1'b0;
            camera_mode  = 1'b0;
            expected_poses.delete();
            errors        = 0;
            poses_checked = 0;
            words_taken   = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_RADIUS_LEFT:  rad_l = longint'(cfg_data[15:0]);
                    CFG_RADIUS_RIGHT: rad_r = longint'(cfg_data[15:0]);
                    CFG_INV_TRACK:    inv_track = longint'(cfg_data);
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                poses_checked++;
                if (expected_poses.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected pose x=%0d y=%0d h=%0d src=%0d", $time,
                             pose_x, pose_y, pose_heading, pose_source);
                end
                else
                begin
                    e = expected_poses.pop_front();
                    if (pose_x !== e.x)
                    begin
                        errors++;
                        $display("%0t: pose_x expected %0d actual %0d", $time, e.x, pose_x);
                    end
                    if (pose_y !== e.y)
                    begin
                        errors++;
                        $display("%0t: pose_y expected %0d actual %0d", $time, e.y, pose_y);
                    end
                    if (pose_heading !== e.heading)
                    begin
                        errors++;
                        $display("%0t: pose_heading expected %0d actual %0d", $time,
                                 e.heading, pose_heading);
                    end
                    if (pose_source !== e.source)
                    begin
                        errors++;
                        $display("%0t: pose_source expected %0d actual %0d", $time,
                                 e.source, pose_source);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                words_taken++;
                case (opcode)
                    OP_ENCODER:
                    begin
                        advance_odometry(longint'(wheel_delta_left),
                                         longint'(wheel_delta_right));
                        odom_fresh = 1'b1;
                    end
                    OP_CAMERA:
                    begin
                        camera       = '{cam_x, cam_y, cam_heading};
                        camera_fresh = cam_x < CAM_LIMIT;
                    end
                    OP_TOGGLE:
                        camera_mode = !camera_mode;
                    default:
                        publish_tick();
                endcase
            end
        end
        pending = expected_poses.size();
    end

endmodule

@@ sim/odometry_pose_fusion_tb.sv @@
// Top of the odometry pose fusion testbench: clock, reset, configuration phases and
// word stimulus with idling and back-pressure. Depends on opf_pkg, the block
// and opf_checker, which does all prediction and comparison.
`timescale 1ns / 100ps

module odometry_pose_fusion_tb;
    import opf_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [23:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         opcode;
    logic signed [31:0] wheel_delta_left;
    logic signed [31:0] wheel_delta_right;
    logic signed [31:0] cam_x;
    logic signed [31:0] cam_y;
    logic signed [31:0] cam_heading;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [31:0] pose_heading;
    logic               pose_source;

    int errors, pending, poses_checked, words_taken;
    int idle_pct  = 0;
    int stall_pct = 0;
    int hold_left = 0;
    logic hold_go   = 1'b0;
    logic hold_done = 1'b0;

    localparam logic signed [31:0] CAM_X_INVALID = 32'sd5000 <<< 16;
    // Register index with no register behind it.
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    odometry_pose_fusion dut (.*);

    opf_checker checker_i (.*);

    // Clock, 20 ns period.
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Receiver back-pressure: random stalls plus one long hold-off.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (hold_go && !hold_done)
        begin
            hold_left <= 400;
            hold_done <= 1'b1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99, 0) < stall_pct);
    end

    initial
    begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic send_word(input logic [1:0] op, input logic signed [31:0] dl,
                             input logic signed [31:0] dr, input logic signed [31:0] cx,
                             input logic signed [31:0] cy, input logic signed [31:0] ch);
        if ($urandom_range(99, 0) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99, 0) < idle_pct)
                @(posedge clk);
        end
        in_valid          <= 1'b1;
        opcode            <= op;
        wheel_delta_left  <= dl;
        wheel_delta_right <= dr;
        cam_x             <= cx;
        cam_y             <= cy;
        cam_heading       <= ch;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic encoder(input logic signed [31:0] dl, input logic signed [31:0] dr);
        send_word(OP_ENCODER, dl, dr, $urandom, $urandom, $urandom);
    endtask

    task automatic camera(input logic signed [31:0] cx, input logic signed [31:0] cy,
                          input logic signed [31:0] ch);
        send_word(OP_CAMERA, $urandom, $urandom, cx, cy, ch);
    endtask

    task automatic plain(input logic [1:0] op);
        send_word(op, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    // Drop valid and wait until every pose is out and the block has settled.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic set_geometry(input logic [15:0] rl, input logic [15:0] rr,
                                input logic [23:0] it);
        write_reg(CFG_RADIUS_LEFT, {8'd0, rl});
        write_reg(CFG_RADIUS_RIGHT, {8'd0, rr});
        write_reg(CFG_INV_TRACK, it);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [31:0] wheel_step();
        case ($urandom_range(7, 0))
            0: return $urandom;
            1: return $urandom_range(1, 0) ? 32'sh7FFFFFFF : 32'sh80000000;
            default: return $signed($urandom_range(262144, 0)) - 32'sd131072;
        endcase
    endfunction

    function automatic logic signed [31:0] camera_x();
        case ($urandom_range(7, 0))
            0: return $urandom;
            1: return CAM_X_INVALID + $signed($urandom_range(2, 0)) - 32'sd1;
            default: return $signed($urandom_range(2000000, 0)) - 32'sd1000000;
        endcase
    endfunction

    function automatic logic signed [31:0] camera_heading();
        if ($urandom_range(7, 0) == 0)
            return $urandom;
        return $signed($urandom_range(1686629713, 0)) - 32'sd843314856;
    endfunction

    // Mostly encoder or camera words followed by a tick, with toggles and noise.
    task automatic random_words(input int count);
        int sent;
        int r;
        sent = 0;
        while (sent < count)
        begin
            r = $urandom_range(99, 0);
            if (r < 55)
            begin
                encoder(wheel_step(), wheel_step());
                plain(OP_TICK);
                sent += 2;
            end
            else if (r < 72)
            begin
                camera(camera_x(), $urandom, camera_heading());
                if ($urandom_range(1, 0))
                    encoder(wheel_step(), wheel_step());
                plain(OP_TICK);
                sent += 2;
            end
            else if (r < 82)
            begin
                plain(OP_TOGGLE);
                sent++;
            end
            else
            begin
                send_word(2'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom);
                sent++;
            end
        end
    endtask

    // Stimulus and verdict.
    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_RADIUS_LEFT;
        cfg_data          = '0;
        in_valid          = 1'b0;
        out_stall         = 1'b0;
        opcode            = OP_TICK;
        wheel_delta_left  = '0;
        wheel_delta_right = '0;
        cam_x             = '0;
        cam_y             = '0;
        cam_heading       = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset geometry, no idling.
        set_geometry(RADIUS_RESET, RADIUS_RESET, INV_TRACK_RESET);
        write_reg(CFG_UNUSED, 24'hFFFFFF);
        cfg_we <= 1'b0;
        plain(OP_TICK);                                   // nothing to publish
        encoder(32'sd0, 32'sd0);
        plain(OP_TICK);
        encoder(32'sh7FFFFFFF, 32'sh7FFFFFFF);
        plain(OP_TICK);
        encoder(32'sh80000000, 32'sh7FFFFFFF);            // huge heading change
        plain(OP_TICK);
        camera(32'sd65536, -32'sd65536, 32'sd100000);
        plain(OP_TICK);                                   // camera mode off, nothing fresh
        plain(OP_TOGGLE);
        plain(OP_TICK);
        camera(CAM_X_INVALID, 32'sd0, 32'sd0);            // invalid camera pose
        plain(OP_TICK);
        camera(32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF); // heading out of range
        plain(OP_TICK);
        encoder(32'sd65536, -32'sd65536);
        plain(OP_TICK);
        camera(CAM_X_INVALID - 32'sd1, 32'sd0, 32'sh80000000);
        encoder(32'sh80000000, 32'sh80000000);
        plain(OP_TICK);                                   // camera wins over odometry
        plain(OP_TOGGLE);
        camera(32'sd0, 32'sd0, 32'sd0);
        encoder(32'sd1000, 32'sd2000);
        plain(OP_TICK);                                   // mode off: odometry
        random_words(120);
        drain();

        set_geometry(16'($urandom), 16'($urandom), 24'($urandom));
        idle_pct = 77;
        random_words(140);
        drain();

        set_geometry(16'hFFFF, 16'hFFFF, 24'hFFFFFF);
        idle_pct  = 0;
        stall_pct = 77;
        random_words(140);
        drain();

        set_geometry(16'd0, 16'd0, 24'd0);
        idle_pct  = 16;
        stall_pct = 16;
        random_words(120);
        drain();

        // Long receiver hold-off while words keep coming.
        set_geometry(16'($urandom), 16'($urandom), 24'($urandom_range(600000, 0)));
        idle_pct  = 0;
        stall_pct = 0;
        hold_go  <= 1'b1;
        random_words(160);
        drain();

        $display("Covered %0d input words and %0d published poses over five geometry",
                 words_taken, poses_checked);
        $display("settings, with idle, stall and long hold-off phases.");
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
